// ===== design/pts_pkg.sv =====
package pts_pkg;

  typedef enum logic [2:0] {
    MODE_TICK        = 3'd0,
    MODE_DISPATCH    = 3'd1,
    MODE_CREATE      = 3'd2,
    MODE_SET_STATE   = 3'd3,
    MODE_SET_PERIOD  = 3'd4,
    MODE_SET_COUNTER = 3'd5,
    MODE_READ        = 3'd6,
    MODE_UNUSED      = 3'd7
  } mode_t;

  localparam logic [1:0] SLOT_BLOCKED   = 2'd0;
  localparam logic [1:0] SLOT_READY     = 2'd1;
  localparam logic [1:0] SLOT_SUSPENDED = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_LIMIT = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam logic [1:0] CFG_CHECK = 2'd0;
  localparam logic [1:0] CFG_MIN   = 2'd1;
  localparam logic [1:0] CFG_MAX   = 2'd2;

  localparam logic [7:0] MIN_PERIOD_RST = 8'd1;
  localparam logic [7:0] MAX_PERIOD_RST = 8'd255;

  typedef struct packed {
    logic [1:0] state;
    logic [7:0] period;
    logic [7:0] counter;
  } slot_t;

  typedef struct packed {
    mode_t      mode;
    logic [2:0] task_index;
    logic [7:0] period;
    logic [7:0] counter_value;
    logic [1:0] task_state;
  } item_t;

  typedef struct packed {
    logic       check;
    logic [7:0] min_period;
    logic [7:0] max_period;
  } cfg_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] index;
    logic       dispatched;
    logic [1:0] state;
    logic [7:0] period;
    logic [7:0] counter;
    logic       last;
  } res_t;

  typedef struct packed {
    logic       we;
    logic       emit;
    slot_t      slot;
    logic [1:0] status;
  } alu_out_t;

  // the unused state code is stored as blocked
  function automatic logic [1:0] fix_state(input logic [1:0] s);
    fix_state = (s == 2'd3) ? SLOT_BLOCKED : s;
  endfunction

endpackage

// ===== design/pts_slot_mem.sv =====
module pts_slot_mem
  import pts_pkg::*;
#(
  parameter int DEPTH = 8,
  parameter int IW    = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  slot_t         wdata,
  input  logic [IW-1:0] raddr,
  output slot_t         rdata
);

  slot_t            slot_mem_r [DEPTH];
  logic [DEPTH-1:0] valid_r;
  slot_t            rdata_r;
  logic             rd_ok;

  assign rd_ok = 32'(raddr) < DEPTH;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      slot_mem_r[waddr] <= wdata;
    end
  end

  // entries never written read as the cleared slot
  always_ff @(posedge clk) begin
    if (rd_ok && valid_r[raddr]) begin
      rdata_r <= slot_mem_r[raddr];
    end else begin
      rdata_r <= '0;
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/pts_slot_alu.sv =====
module pts_slot_alu
  import pts_pkg::*;
(
  input  item_t    item,
  input  slot_t    slot,
  input  cfg_t     cfg,
  input  logic     full,
  input  logic     idx_ok,
  output alu_out_t res
);

  always_comb begin
    res        = '0;
    res.slot   = slot;
    res.status = STAT_OK;
    case (item.mode)
      MODE_TICK: begin
        if (slot.state != SLOT_SUSPENDED) begin
          res.we = 1'b1;
          if (slot.period <= slot.counter) begin
            res.slot.counter = 8'd1;
            res.slot.state   = SLOT_READY;
          end else begin
            res.slot.counter = slot.counter + 8'd1;
          end
        end
      end
      MODE_DISPATCH: begin
        if (slot.state == SLOT_READY) begin
          res.we         = 1'b1;
          res.emit       = 1'b1;
          res.slot.state = SLOT_BLOCKED;
        end
      end
      MODE_CREATE: begin
        if (cfg.check && (item.period < cfg.min_period || item.period > cfg.max_period)) begin
          res.status = STAT_LIMIT;
        end else if (full) begin
          res.status = STAT_FULL;
        end else begin
          res.we           = 1'b1;
          res.slot.state   = fix_state(item.task_state);
          res.slot.period  = item.period;
          res.slot.counter = 8'd1;
        end
      end
      MODE_SET_STATE: begin
        res.we         = idx_ok;
        res.slot.state = fix_state(item.task_state);
      end
      MODE_SET_PERIOD: begin
        res.we          = idx_ok;
        res.slot.period = item.period;
      end
      MODE_SET_COUNTER: begin
        res.we           = idx_ok;
        res.slot.counter = item.counter_value;
      end
      default: begin
        res.we = 1'b0;
      end
    endcase
  end

endmodule

// ===== design/periodic_task_scheduler.sv =====
// tick and dispatch sweep the registered slots, one slot per cycle through the single
// read port of the slot memory and the update unit; in dispatch, a ready slot found while
// the previous result waits on out_tready stalls the sweep.
// a new request is taken only while the sequencer is idle, one at a time.
// rst_n is synchronous: clears slot count, table valid bits, state and valid flags, and
// loads config defaults, with no clearing pass.
module periodic_task_scheduler
  import pts_pkg::*;
#(
  parameter int MAX_TASKS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // config write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // task_index[2:0], period[10:3], counter_value[18:11],
                                  // task_state[20:19], zero fill
  input  logic [2:0]  in_tuser,   // mode
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // status[1:0], result_index[4:2], result_state[6:5],
                                  // result_period[14:7], result_counter[22:15], zero fill
  output logic        out_tuser,  // dispatched
  output logic        out_tlast
);

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] addr_r, addr_nxt;
  logic [CW-1:0] n_reg_r, n_reg_nxt;
  logic          hold_v_r, hold_v_nxt;
  res_t          hold_r, hold_nxt;
  logic          out_valid_r, out_valid_nxt;
  res_t          out_r, out_nxt;
  item_t         item_r;
  cfg_t          cfg_r;

  logic          in_acc;
  logic          out_free;
  logic          sweep;
  logic          in_sweep;
  logic          full;
  logic          idx_ok;
  logic          push;
  res_t          push_res;
  logic          mem_we;
  slot_t         rdata;
  alu_out_t      alu;
  mode_t         in_mode;

  assign in_mode   = mode_t'(in_tuser);
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;
  assign full      = (n_reg_r == CW'(MAX_TASKS));
  assign idx_ok    = 32'(item_r.task_index) < MAX_TASKS;
  assign sweep     = (item_r.mode == MODE_TICK) || (item_r.mode == MODE_DISPATCH);
  assign in_sweep  = (in_mode == MODE_TICK) || (in_mode == MODE_DISPATCH);

  pts_slot_mem #(
    .DEPTH (MAX_TASKS),
    .IW    (IW)
  ) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (addr_r[IW-1:0]),
    .wdata (alu.slot),
    .raddr (addr_nxt[IW-1:0]),
    .rdata (rdata)
  );

  pts_slot_alu u_alu (
    .item   (item_r),
    .slot   (rdata),
    .cfg    (cfg_r),
    .full   (full),
    .idx_ok (idx_ok),
    .res    (alu)
  );

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    n_reg_nxt     = n_reg_r;
    hold_v_nxt    = hold_v_r;
    hold_nxt      = hold_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_nxt       = out_r;
    push          = 1'b0;
    push_res      = hold_r;
    mem_we        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_sweep) begin
            addr_nxt  = '0;
            state_nxt = (n_reg_r == '0) ? S_FIN : S_EXEC;
          end else if (in_mode == MODE_CREATE) begin
            addr_nxt  = n_reg_r;
            state_nxt = S_EXEC;
          end else begin
            addr_nxt  = CW'(in_tdata[2:0]);
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (sweep) begin
          // a found slot stalls only when the previous one cannot leave
          if (!(alu.emit && hold_v_r && !out_free)) begin
            mem_we = alu.we;
            if (alu.emit) begin
              push                = hold_v_r;
              hold_v_nxt          = 1'b1;
              hold_nxt            = '0;
              hold_nxt.index      = 3'(addr_r);
              hold_nxt.dispatched = 1'b1;
            end
            addr_nxt = addr_r + 1'b1;
            if (addr_nxt == n_reg_r) begin
              state_nxt = S_FIN;
            end
          end
        end else begin
          mem_we    = alu.we;
          state_nxt = S_FIN;
          case (item_r.mode)
            MODE_CREATE: begin
              hold_v_nxt      = 1'b1;
              hold_nxt        = '0;
              hold_nxt.status = alu.status;
              if (alu.we) begin
                hold_nxt.index = 3'(n_reg_r);
                n_reg_nxt      = n_reg_r + 1'b1;
              end
            end
            MODE_READ: begin
              hold_v_nxt     = 1'b1;
              hold_nxt       = '0;
              hold_nxt.index = item_r.task_index;
              if (idx_ok) begin
                hold_nxt.state   = rdata.state;
                hold_nxt.period  = rdata.period;
                hold_nxt.counter = rdata.counter;
              end
            end
            default: begin
              hold_v_nxt = hold_v_r;
            end
          endcase
        end
      end
      S_FIN: begin
        if (hold_v_r || item_r.mode == MODE_DISPATCH) begin
          if (out_free) begin
            push          = 1'b1;
            push_res      = hold_v_r ? hold_r : '0;
            push_res.last = 1'b1;
            hold_v_nxt    = 1'b0;
            state_nxt     = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (push) begin
      out_nxt       = push_res;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      addr_r      <= '0;
      n_reg_r     <= '0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_r       <= '{check: 1'b0, min_period: MIN_PERIOD_RST, max_period: MAX_PERIOD_RST};
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      n_reg_r     <= n_reg_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CHECK: cfg_r.check      <= cfg_data[0];
          CFG_MIN:   cfg_r.min_period <= cfg_data;
          CFG_MAX:   cfg_r.max_period <= cfg_data;
          default:   cfg_r            <= cfg_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
    if (in_acc) begin
      item_r.mode          <= in_mode;
      item_r.task_index    <= in_tdata[2:0];
      item_r.period        <= in_tdata[10:3];
      item_r.counter_value <= in_tdata[18:11];
      item_r.task_state    <= in_tdata[20:19];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_r.counter, out_r.period, out_r.state, out_r.index,
                       out_r.status};
  assign out_tuser  = out_r.dispatched;
  assign out_tlast  = out_r.last;

endmodule
